### rtl/pds_pkg.sv
// Shared types, constants and a helper function of the PLL divider search block.
package pds_pkg;

  localparam int TGT_W     = 22;
  localparam int REF_W     = 22;
  localparam int MF_W      = 6;
  localparam int ML_W      = 7;
  localparam int M_W       = 6;
  localparam int K_W       = 2;
  localparam int NF_W      = 8;
  localparam int WORD_W    = 16;
  localparam int ACH_W     = 22;
  localparam int DEN_W     = 13;
  localparam int DIV_PRE_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 22;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  localparam int N_LIMIT_DEF = 256;
  localparam int K_COUNT_DEF = 4;

  localparam logic [ACH_W-1:0] ACH_MAX   = 22'h3FFFFF;
  localparam logic [ML_W-1:0]  M_CAP     = 7'd64;
  localparam logic [DEN_W-1:0] DEN_SHORT = 13'd300;

  localparam logic [REF_W-1:0] REF_RST = 22'd1431818;
  localparam logic [MF_W-1:0]  MF_RST  = 6'd1;
  localparam logic [ML_W-1:0]  ML_RST  = 7'd57;

  localparam logic [CFG_IDX_W-1:0] CFG_REF    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MFIRST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MLIMIT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SHORT,
    S_SDIV,
    S_MSTART,
    S_MCHK,
    S_MDIV,
    S_K,
    S_NEXT,
    S_FMUL,
    S_FSTART,
    S_FDIV,
    S_DONE
  } seq_state_t;

  function automatic logic [DEN_W-1:0] den_of(input logic [M_W-1:0] m);
    logic [DEN_W-1:0] m2;
    m2 = DEN_W'(m) + DEN_W'(2);
    return DEN_W'(m2 * DEN_W'(100));
  endfunction

endpackage

### rtl/pds_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module pds_div
  import pds_pkg::*;
#(
  parameter int NUM_W = 31,
  parameter int Q_W   = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [Q_W-1:0]   quo_o
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]   quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh  = {rem_r, quo_r[Q_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
  assign quo_nxt = {quo_r[Q_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= DEN_W'(num_i[NUM_W-1:Q_W]);
      quo_r <= num_i[Q_W-1:0];
      den_r <= den_i;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy_o = busy_r;
  assign done_o = done_r;
  assign quo_o  = quo_r;

endmodule

### rtl/pds_seq.sv
// Search sequencer: loop counters, candidate compare and best-setting registers.
module pds_seq
  import pds_pkg::*;
#(
  parameter int N_LIMIT = N_LIMIT_DEF,
  parameter int K_COUNT = K_COUNT_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start_i,
  input  logic [TGT_W-1:0]                        target_i,
  input  logic [REF_W-1:0]                        ref_i,
  input  logic [MF_W-1:0]                         m_first_i,
  input  logic [ML_W-1:0]                         m_lim_i,
  output logic                                    idle_o,
  output logic                                    res_valid_o,
  input  logic                                    res_ready_i,
  output logic [WORD_W-1:0]                       res_word_o,
  output logic [ACH_W-1:0]                        res_ach_o,
  output logic                                    div_start_o,
  output logic [REF_W+$clog2(N_LIMIT):0]          div_num_o,
  output logic [DEN_W-1:0]                        div_den_o,
  input  logic                                    div_done_i,
  input  logic [REF_W+$clog2(N_LIMIT)-DIV_PRE_W:0] div_quo_i
);

  localparam int NW    = $clog2(N_LIMIT);
  localparam int NUM_W = REF_W + NW + 1;
  localparam int Q_W   = NUM_W - DIV_PRE_W;
  localparam int E_W   = (Q_W > TGT_W) ? Q_W : TGT_W;
  localparam int CW    = (NUM_W > TGT_W + 7) ? NUM_W : TGT_W + 7;
  localparam logic [NW-1:0]  N_LAST = NW'(N_LIMIT - 1);
  localparam logic [K_W-1:0] K_LAST = K_W'(K_COUNT - 1);

  seq_state_t state_r, state_nxt;

  logic [NW-1:0]    n_r, bn_r, mul_n;
  logic [ML_W-1:0]  m_r;
  logic [M_W-1:0]   bm_r;
  logic [K_W-1:0]   k_r, bk_r;
  logic [TGT_W-1:0] tgt_r;
  logic [CW-1:0]    t100_r;
  logic [NUM_W-1:0] num_r, mul_res;
  logic [Q_W-1:0]   q_r, kf, ff;
  logic [E_W-1:0]   best_err_r, sc_err, kf_e, tg_e, k_err, ff_e;
  logic [ACH_W-1:0] ach_r, ach_nxt;
  logic [NW:0]      n2;
  logic             short_hit, sc_better, k_better, m_in_range;

  assign mul_n   = (state_r == S_FMUL) ? bn_r : n_r;
  assign n2      = (NW+1)'(mul_n) + (NW+1)'(2);
  assign mul_res = NUM_W'(ref_i) * NUM_W'(n2);

  assign short_hit  = CW'(num_r) < t100_r;
  assign m_in_range = m_r < m_lim_i;
  assign tg_e       = E_W'(tgt_r);
  assign sc_err     = tg_e - E_W'(div_quo_i);
  assign sc_better  = sc_err < best_err_r;

  assign kf       = q_r >> k_r;
  assign kf_e     = E_W'(kf);
  assign k_err    = (kf_e > tg_e) ? kf_e - tg_e : tg_e - kf_e;
  assign k_better = k_err < best_err_r;

  assign ff      = div_quo_i >> bk_r;
  assign ff_e    = E_W'(ff);
  assign ach_nxt = (ff_e > E_W'(ACH_MAX)) ? ACH_MAX : ff_e[ACH_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start_i) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_SHORT;
      S_SHORT:  state_nxt = short_hit ? S_SDIV : S_MSTART;
      S_SDIV:   if (div_done_i) state_nxt = sc_better ? S_NEXT : S_MSTART;
      S_MSTART: state_nxt = S_MCHK;
      S_MCHK:   state_nxt = m_in_range ? S_MDIV : S_NEXT;
      S_MDIV:   if (div_done_i) state_nxt = S_K;
      S_K:      if (k_r == K_LAST) state_nxt = S_MCHK;
      S_NEXT:   state_nxt = (n_r == N_LAST) ? S_FMUL : S_MUL;
      S_FMUL:   state_nxt = S_FSTART;
      S_FSTART: state_nxt = S_FDIV;
      S_FDIV:   if (div_done_i) state_nxt = S_DONE;
      S_DONE:   if (res_ready_i) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    div_start_o = 1'b0;
    div_den_o   = DEN_SHORT;
    idle_o      = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_r)
      S_IDLE:   idle_o = 1'b1;
      S_SHORT:  div_start_o = short_hit;
      S_MCHK: begin
        div_start_o = m_in_range;
        div_den_o   = den_of(m_r[M_W-1:0]);
      end
      S_FSTART: begin
        div_start_o = 1'b1;
        div_den_o   = den_of(bm_r);
      end
      S_DONE:   res_valid_o = 1'b1;
      default:  div_start_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (start_i) begin
          tgt_r      <= target_i;
          t100_r     <= CW'(CW'(target_i) * CW'(100));
          best_err_r <= E_W'(target_i);
          bn_r       <= '0;
          bm_r       <= '0;
          bk_r       <= '0;
          n_r        <= NW'(1);
        end
      end
      S_MUL, S_FMUL: num_r <= mul_res;
      S_SDIV: begin
        if (div_done_i && sc_better) begin
          best_err_r <= sc_err;
          bn_r       <= n_r;
          bm_r       <= M_W'(1);
          bk_r       <= '0;
        end
      end
      S_MSTART: m_r <= ML_W'(m_first_i);
      S_MDIV: begin
        if (div_done_i) begin
          q_r <= div_quo_i;
          k_r <= '0;
        end
      end
      S_K: begin
        if (k_better) begin
          best_err_r <= k_err;
          bn_r       <= n_r;
          bm_r       <= m_r[M_W-1:0];
          bk_r       <= k_r;
        end
        if (k_r == K_LAST) begin
          m_r <= m_r + ML_W'(1);
        end else begin
          k_r <= k_r + K_W'(1);
        end
      end
      S_NEXT: if (n_r != N_LAST) n_r <= n_r + NW'(1);
      S_FDIV: if (div_done_i) ach_r <= ach_nxt;
      default: ach_r <= ach_r;
    endcase
  end

  assign div_num_o  = num_r;
  assign res_word_o = {NF_W'(bn_r), bm_r, bk_r};
  assign res_ach_o  = ach_r;

endmodule

### rtl/pll_divider_search_top.sv
// Top level of the PLL divider search: stream ports, configuration registers, result register.
//
// The block takes a wanted clock in kHz on the in_ stream and returns one result on the out_
// stream: the packed PLL setting (n, m, k) whose output frequency lies nearest the wanted clock,
// and the frequency that setting achieves. The cfg_ channel writes the reference clock, the
// first m and the m bound; it is always ready and should only be used while the block is idle.
// One request at a time is searched; in_tready is high only while the sequencer is idle.
// A search walks n over 1 to N_LIMIT-1 and, for each n not settled by the shortcut candidate,
// every m in range. Each divide runs in the shared restoring divider, one quotient bit per
// cycle (24 bits with N_LIMIT of 256); then the K_COUNT k candidates are compared in turn.
// Finishing divides the best setting once more to find the frequency that it achieves.
// The result sits in an output register; a new request can be accepted while it waits.
// If the receiver stalls, a finished search holds in its last state until the output register
// frees up. Synchronous reset restores the register defaults (reference 14318.18 kHz, m from
// 1 to 56) and drops any request in flight.
module pll_divider_search_top
  import pds_pkg::*;
#(
  parameter int N_LIMIT = N_LIMIT_DEF,
  parameter int K_COUNT = K_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // target_khz[21:0], zero padding
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // pll_word[15:0], achieved_khz[37:16], zero padding
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DAT_W-1:0]   cfg_data
);

  localparam int NW    = $clog2(N_LIMIT);
  localparam int NUM_W = REF_W + NW + 1;
  localparam int Q_W   = NUM_W - DIV_PRE_W;

  logic [REF_W-1:0] ref_r;
  logic [MF_W-1:0]  mf_r;
  logic [ML_W-1:0]  ml_r, m_lim;

  logic                     seq_idle, res_valid, res_ready, res_load;
  logic [WORD_W-1:0]        res_word;
  logic [ACH_W-1:0]         res_ach;
  logic                     div_start, div_busy, div_done;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic [Q_W-1:0]           div_quo;
  logic                     out_tvalid_r;
  logic [OUT_TDATA_W-1:0]   out_tdata_r;

  assign cfg_ready = 1'b1;
  assign m_lim     = (ml_r > M_CAP) ? M_CAP : ml_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_RST;
      mf_r  <= MF_RST;
      ml_r  <= ML_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_REF) ref_r <= cfg_data;
      if (cfg_index == CFG_MFIRST) mf_r <= cfg_data[MF_W-1:0];
      if (cfg_index == CFG_MLIMIT) ml_r <= cfg_data[ML_W-1:0];
    end
  end

  pds_seq #(
    .N_LIMIT (N_LIMIT),
    .K_COUNT (K_COUNT)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (in_tvalid && in_tready),
    .target_i    (in_tdata[TGT_W-1:0]),
    .ref_i       (ref_r),
    .m_first_i   (mf_r),
    .m_lim_i     (m_lim),
    .idle_o      (seq_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_word_o  (res_word),
    .res_ach_o   (res_ach),
    .div_start_o (div_start),
    .div_num_o   (div_num),
    .div_den_o   (div_den),
    .div_done_i  (div_done),
    .div_quo_i   (div_quo)
  );

  pds_div #(
    .NUM_W (NUM_W),
    .Q_W   (Q_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign in_tready = seq_idle;
  assign res_ready = !out_tvalid_r || out_tready;
  assign res_load  = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_tdata_r <= {(OUT_TDATA_W - WORD_W - ACH_W)'(0), res_ach, res_word};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice without a search in between");

  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> out_tvalid && out_tdata[WORD_W-1:0] == $past(res_word))
    else $error("finished result not placed in output register");

endmodule
